// ===== hw/rtl/nearest_waypoint_lookahead_defines.svh =====
// assertion macros for the nearest waypoint lookahead block
`ifndef NEAREST_WAYPOINT_LOOKAHEAD_DEFINES_SVH
`define NEAREST_WAYPOINT_LOOKAHEAD_DEFINES_SVH
`ifndef SYNTHESIS
`define NWL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define NWL_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define NWL_ASSERT(lbl, prop, msg)
`define NWL_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ===== hw/rtl/nwl_pkg.sv =====
// shared types, constants and tables of the nearest waypoint lookahead block
`default_nettype none

package nwl_pkg;

  localparam int unsigned COORD_W      = 24;
  localparam int unsigned DIFF_W       = 25;
  localparam int unsigned SQ_W         = 48;
  localparam int unsigned HEAD_W       = 16;
  localparam int unsigned IDX_OUT_W    = 10;
  localparam int unsigned LOOK_W       = 8;
  localparam int unsigned PT_W         = 2 * COORD_W;
  localparam int unsigned CX_W         = 52;
  localparam int unsigned Z_W          = 24;
  localparam int unsigned SCALE_SH     = 24;
  localparam int unsigned ROUND_SH     = 7;
  localparam int unsigned CORDIC_ITERS = 20;
  localparam int unsigned ITER_W       = 5;
  localparam int unsigned APB_AW       = 3;
  localparam int unsigned APB_DW       = 32;

  localparam logic [LOOK_W-1:0]    LOOKAHEAD_RESET = 8'd20;
  localparam logic signed [Z_W-1:0] HALF_PI_Q20    = 24'sd1647099;
  localparam logic signed [Z_W-1:0] HEADING_LIMIT  = 24'sd25736;

  localparam logic ACT_APPEND = 1'b0;
  localparam logic ACT_QUERY  = 1'b1;

  localparam logic REG_LOOKAHEAD = 1'b0;

  typedef struct packed {
    logic                      action;
    logic                      restart;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
  } nwl_in_t;

  typedef struct packed {
    logic                      found;
    logic [IDX_OUT_W-1:0]      goal_index;
    logic signed [COORD_W-1:0] goal_x;
    logic signed [COORD_W-1:0] goal_y;
    logic signed [HEAD_W-1:0]  goal_heading;
  } nwl_out_t;

  typedef struct packed {
    logic clear;
    logic valid;
  } dist_ctl_t;

  typedef struct packed {
    logic                     start;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
  } cordic_req_t;

  typedef struct packed {
    logic                     busy;
    logic                     done;
    logic signed [HEAD_W-1:0] heading;
  } cordic_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_PICK,
    ST_RD_GOAL,
    ST_RD_NBR,
    ST_DIFF,
    ST_HEAD,
    ST_FINISH
  } nwl_state_e;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_ITER,
    CS_ROUND,
    CS_DONE
  } cordic_state_e;

  function automatic logic signed [Z_W-1:0] atan_q20(input logic [ITER_W-1:0] idx);
    logic signed [Z_W-1:0] v;
    unique case (idx)
      5'd0:    v = 24'sd823550;
      5'd1:    v = 24'sd486170;
      5'd2:    v = 24'sd256879;
      5'd3:    v = 24'sd130396;
      5'd4:    v = 24'sd65451;
      5'd5:    v = 24'sd32757;
      5'd6:    v = 24'sd16383;
      5'd7:    v = 24'sd8192;
      5'd8:    v = 24'sd4096;
      5'd9:    v = 24'sd2048;
      5'd10:   v = 24'sd1024;
      5'd11:   v = 24'sd512;
      5'd12:   v = 24'sd256;
      5'd13:   v = 24'sd128;
      5'd14:   v = 24'sd64;
      5'd15:   v = 24'sd32;
      5'd16:   v = 24'sd16;
      5'd17:   v = 24'sd8;
      5'd18:   v = 24'sd4;
      5'd19:   v = 24'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/nwl_dist.sv =====
// pipelined squared distance and first minimum tracker for the waypoint scan
`default_nettype none

module nwl_dist import nwl_pkg::*; #(
  parameter int unsigned IDX_W = 10
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  dist_ctl_t                 ctl_i,
  input  logic [IDX_W-1:0]          idx_i,
  input  logic signed [COORD_W-1:0] pt_x_i,
  input  logic signed [COORD_W-1:0] pt_y_i,
  input  logic signed [COORD_W-1:0] qx_i,
  input  logic signed [COORD_W-1:0] qy_i,
  output logic                      busy_o,
  output logic [IDX_W-1:0]          best_o
);

  logic                       v1_q, v2_q, have_q;
  logic [IDX_W-1:0]           i1_q, i2_q, best_q;
  logic signed [DIFF_W-1:0]   dx1_q, dy1_q, dx_d, dy_d;
  logic signed [2*DIFF_W-1:0] px, py;
  logic [SQ_W-1:0]            sx2_q, sy2_q;
  logic [SQ_W:0]              d_sum, best_d_q;
  logic                       take;

  assign dx_d  = DIFF_W'(qx_i) - DIFF_W'(pt_x_i);
  assign dy_d  = DIFF_W'(qy_i) - DIFF_W'(pt_y_i);
  assign px    = dx1_q * dx1_q;
  assign py    = dy1_q * dy1_q;
  assign d_sum = {1'b0, sx2_q} + {1'b0, sy2_q};
  assign take  = v2_q && (!have_q || (d_sum < best_d_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      have_q <= 1'b0;
    end else begin
      v1_q <= ctl_i.valid;
      v2_q <= v1_q;
      if (ctl_i.clear) begin
        have_q <= 1'b0;
      end else if (take) begin
        have_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    i1_q  <= idx_i;
    dx1_q <= dx_d;
    dy1_q <= dy_d;
    i2_q  <= i1_q;
    sx2_q <= px[SQ_W-1:0];
    sy2_q <= py[SQ_W-1:0];
    if (take) begin
      best_d_q <= d_sum;
      best_q   <= i2_q;
    end
  end

  assign busy_o = v1_q || v2_q;
  assign best_o = best_q;

endmodule

`default_nettype wire

// ===== hw/rtl/nwl_cordic.sv =====
// iterative vectoring cordic that turns a path step into a heading
`default_nettype none
`include "nearest_waypoint_lookahead_defines.svh"

module nwl_cordic import nwl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cordic_req_t req_i,
  output cordic_rsp_t rsp_o
);

  cordic_state_e            cst_q, cst_d;
  logic [ITER_W-1:0]        iter_q;
  logic signed [CX_W-1:0]   x_q, y_q, xs, ys, dxe, dye;
  logic signed [Z_W-1:0]    z_q, zr, zs, zc, atan_v;
  logic signed [HEAD_W-1:0] head_q;
  logic                     zero_in, last_iter;

  assign dxe       = CX_W'(req_i.dx) <<< SCALE_SH;
  assign dye       = CX_W'(req_i.dy) <<< SCALE_SH;
  assign zero_in   = (req_i.dx == '0) && (req_i.dy == '0);
  assign last_iter = (iter_q == ITER_W'(CORDIC_ITERS - 1));
  assign xs        = x_q >>> iter_q;
  assign ys        = y_q >>> iter_q;
  assign atan_v    = atan_q20(iter_q);
  assign zr        = z_q + Z_W'(1 << (ROUND_SH - 1));
  assign zs        = zr >>> ROUND_SH;

  always_comb begin
    priority if (zs > HEADING_LIMIT) begin
      zc = HEADING_LIMIT;
    end else if (zs < -HEADING_LIMIT) begin
      zc = -HEADING_LIMIT;
    end else begin
      zc = zs;
    end
  end

  // next state
  always_comb begin
    cst_d = cst_q;
    unique case (cst_q)
      CS_IDLE: begin
        if (req_i.start) begin
          cst_d = zero_in ? CS_ROUND : CS_ITER;
        end
      end
      CS_ITER: begin
        if (last_iter) begin
          cst_d = CS_ROUND;
        end
      end
      CS_ROUND: cst_d = CS_DONE;
      CS_DONE:  cst_d = CS_IDLE;
      default:  cst_d = CS_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    rsp_o.busy    = (cst_q != CS_IDLE);
    rsp_o.done    = (cst_q == CS_DONE);
    rsp_o.heading = head_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cst_q  <= CS_IDLE;
      iter_q <= '0;
    end else begin
      cst_q <= cst_d;
      if (cst_q == CS_ITER) begin
        iter_q <= iter_q + ITER_W'(1);
      end else begin
        iter_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cst_q)
      CS_IDLE: begin
        if (req_i.start) begin
          // quadrant pre-rotation for steps pointing left
          priority if (zero_in) begin
            x_q <= '0;
            y_q <= '0;
            z_q <= '0;
          end else if (dxe < 0 && dye >= 0) begin
            x_q <= dye;
            y_q <= -dxe;
            z_q <= HALF_PI_Q20;
          end else if (dxe < 0) begin
            x_q <= -dye;
            y_q <= dxe;
            z_q <= -HALF_PI_Q20;
          end else begin
            x_q <= dxe;
            y_q <= dye;
            z_q <= '0;
          end
        end
      end
      CS_ITER: begin
        if (!y_q[CX_W-1]) begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= z_q + atan_v;
        end else begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= z_q - atan_v;
        end
      end
      CS_ROUND: head_q <= HEAD_W'(zc);
      CS_DONE:  ;
      default:  ;
    endcase
  end

  `NWL_ASSERT(a_start_idle, req_i.start |-> cst_q == CS_IDLE, "cordic start while busy")
  `NWL_ASSERT(a_iter_bound, cst_q == CS_ITER |-> iter_q < ITER_W'(CORDIC_ITERS), "iteration overrun")
  `NWL_ASSERT(a_round_src, cst_q == CS_ROUND |-> $past(cst_q == CS_ITER) || $past(cst_q == CS_IDLE), "bad round entry")

endmodule

`default_nettype wire

// ===== hw/rtl/nearest_waypoint_lookahead.sv =====
// top level: waypoint store, scan sequencer, register port and result register
//
// Request channel in_*: valid/stall. action 0 appends the waypoint (restart
// empties the store first, appends to a full store are dropped); action 1
// queries the goal for the vehicle position. Result channel out_*: valid/stall,
// one result per query, none per append. lookahead_steps sits at byte address
// 0 of the APB-style port and must be written while the block is idle.
// A query scans the N stored points through the single read port of the store
// (one point per cycle into a three-stage distance pipeline), then reads the
// goal point and its neighbour and runs the 20-step cordic unit. An empty store
// skips the scan. in_stall_o is high while a query is being worked on.
// The result sits in an output register; a stalled receiver holds it and
// blocks only the end of the next query, appends still go in.
// Reset empties the store (count to zero, contents left as they are), sets
// lookahead_steps to 20 and drops any pending result. No clearing pass.
`default_nettype none
`include "nearest_waypoint_lookahead_defines.svh"

module nearest_waypoint_lookahead import nwl_pkg::*; #(
  parameter int unsigned MAX_POINTS = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  nwl_in_t           in_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output nwl_out_t          out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam int unsigned GW = ((AW > LOOK_W) ? AW : LOOK_W) + 2;

  nwl_state_e state_q, state_d;

  logic [PT_W-1:0]           mem_q [MAX_POINTS];
  logic [PT_W-1:0]           rdata_q;
  logic [AW-1:0]             rd_addr, wr_addr;
  logic                      wr_en;

  logic [CW-1:0]             count_q, count_d;
  logic [LOOK_W-1:0]         lookahead_q;
  logic [AW-1:0]             scan_idx_q, rd_idx_q, goal_q, nbr_q, best_idx, goal_pick;
  logic                      rd_valid_q, scan_issue, scan_last;
  logic signed [COORD_W-1:0] qx_q, qy_q, pt_x, pt_y, res_x_q, res_y_q;
  logic signed [HEAD_W-1:0]  res_head_q;
  logic                      res_found_q, fwd_q, none_q, has_next;
  logic [GW-1:0]             sum_ext;
  logic                      in_acc, cfg_wr, load_out, out_free, dist_busy;
  logic                      out_valid_q;
  nwl_out_t                  out_q;
  dist_ctl_t                 dctl;
  cordic_req_t               creq;
  cordic_rsp_t               crsp;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == REG_LOOKAHEAD) ? APB_DW'(lookahead_q) : '0;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign scan_last = ((CW'(scan_idx_q) + CW'(1)) == count_q);
  assign pt_x      = rdata_q[PT_W-1:COORD_W];
  assign pt_y      = rdata_q[COORD_W-1:0];
  assign sum_ext   = GW'(best_idx) + GW'(lookahead_q);
  assign goal_pick = (sum_ext < GW'(count_q)) ? sum_ext[AW-1:0] : best_idx;
  assign has_next  = (GW'(goal_q) + GW'(1)) < GW'(count_q);

  // store write on append
  always_comb begin
    wr_en   = in_acc && (in_i.action == ACT_APPEND) &&
              (in_i.restart || (count_q < CW'(MAX_POINTS)));
    wr_addr = in_i.restart ? '0 : count_q[AW-1:0];
    count_d = count_q;
    if (wr_en) begin
      count_d = in_i.restart ? CW'(1) : count_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= {in_i.coord_x, in_i.coord_y};
    end
    rdata_q <= mem_q[rd_addr];
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && in_i.action == ACT_QUERY) begin
          state_d = (count_q == '0) ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_valid_q && !dist_busy) begin
          state_d = ST_PICK;
        end
      end
      ST_PICK:    state_d = ST_RD_GOAL;
      ST_RD_GOAL: state_d = ST_RD_NBR;
      ST_RD_NBR:  state_d = ST_DIFF;
      ST_DIFF:    state_d = none_q ? ST_FINISH : ST_HEAD;
      ST_HEAD: begin
        if (crsp.done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall_o  = (state_q != ST_IDLE);
    scan_issue  = (state_q == ST_SCAN);
    load_out    = (state_q == ST_FINISH) && out_free;
    dctl.clear  = in_acc && (in_i.action == ACT_QUERY);
    dctl.valid  = rd_valid_q;
    creq.start  = (state_q == ST_DIFF) && !none_q;
    creq.dx     = fwd_q ? (DIFF_W'(pt_x) - DIFF_W'(res_x_q))
                        : (DIFF_W'(res_x_q) - DIFF_W'(pt_x));
    creq.dy     = fwd_q ? (DIFF_W'(pt_y) - DIFF_W'(res_y_q))
                        : (DIFF_W'(res_y_q) - DIFF_W'(pt_y));
    unique case (state_q)
      ST_SCAN:    rd_addr = scan_idx_q;
      ST_RD_NBR:  rd_addr = nbr_q;
      default:    rd_addr = goal_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      lookahead_q <= LOOKAHEAD_RESET;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      rd_valid_q <= scan_issue;
      if (cfg_wr && paddr[2] == REG_LOOKAHEAD) begin
        lookahead_q <= pwdata[LOOK_W-1:0];
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= scan_idx_q;
    if (scan_issue) begin
      scan_idx_q <= scan_idx_q + AW'(1);
    end
    if (in_acc && in_i.action == ACT_QUERY) begin
      qx_q        <= in_i.coord_x;
      qy_q        <= in_i.coord_y;
      scan_idx_q  <= '0;
      res_found_q <= (count_q != '0);
      goal_q      <= '0;
      res_x_q     <= '0;
      res_y_q     <= '0;
      res_head_q  <= '0;
    end
    if (state_q == ST_PICK) begin
      goal_q <= goal_pick;
    end
    if (state_q == ST_RD_GOAL) begin
      fwd_q  <= has_next;
      none_q <= !has_next && (goal_q == '0);
      nbr_q  <= has_next ? goal_q + AW'(1) : goal_q - AW'(1);
    end
    if (state_q == ST_RD_NBR) begin
      res_x_q <= pt_x;
      res_y_q <= pt_y;
    end
    if (state_q == ST_HEAD && crsp.done) begin
      res_head_q <= crsp.heading;
    end
    if (load_out) begin
      out_q.found        <= res_found_q;
      out_q.goal_index   <= IDX_OUT_W'(goal_q);
      out_q.goal_x       <= res_x_q;
      out_q.goal_y       <= res_y_q;
      out_q.goal_heading <= res_head_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  nwl_dist #(
    .IDX_W (AW)
  ) u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (dctl),
    .idx_i  (rd_idx_q),
    .pt_x_i (pt_x),
    .pt_y_i (pt_y),
    .qx_i   (qx_q),
    .qy_i   (qy_q),
    .busy_o (dist_busy),
    .best_o (best_idx)
  );

  nwl_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (creq),
    .rsp_o  (crsp)
  );

  `NWL_ASSERT(a_count_bound, count_q <= CW'(MAX_POINTS), "point count over capacity")
  `NWL_ASSERT(a_query_scan, in_acc && in_i.action == ACT_QUERY && count_q != '0 |=> state_q == ST_SCAN, "query did not start scan")
  `NWL_ASSERT(a_goal_bound, state_q == ST_RD_GOAL |-> GW'(goal_q) < GW'(count_q), "goal beyond stored points")
  `NWL_ASSERT(a_head_done, crsp.done |-> state_q == ST_HEAD, "heading done outside wait")
  `NWL_ASSERT_RST(a_reset_out, !rst_ni |=> !out_valid_o, "result valid after reset")

endmodule

`default_nettype wire
